// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// check an implication at every rising clock edge outside reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons))

`endif

// ===== hw/rtl/rosg_pkg.sv =====
// register indices and shared types of the rounded outline span generator
package rosg_pkg;

    // configuration register indices
    typedef enum logic [2:0] {
        REG_RECT_LEFT        = 3'd0,
        REG_RECT_TOP         = 3'd1,
        REG_RECT_WIDTH       = 3'd2,
        REG_RECT_HEIGHT      = 3'd3,
        REG_CORNER_RADIUS    = 3'd4,
        REG_STROKE_THICKNESS = 3'd5
    } cfg_reg_t;

    localparam int CFG_INDEX_BITS = 3;

endpackage

// ===== hw/rtl/rounded_outline_span_generator.sv =====
// rounded rectangle outline span generator, top level
//
// Usage:
//   configuration: write registers over cfg_valid/cfg_ready/cfg_index/cfg_wdata
//   (cfg_ready is always high) while no row is in flight.
//   input: one scanline row per transaction on s_tvalid/s_tready/s_tdata.
//   output: one transaction on m_tvalid/m_tready/m_tdata per row that lies in a
//   drawable rectangle; rows outside it, or an empty shape, give no output.
//   throughput: one row per cycle while the output is not stalled, set by the fully
//   pipelined datapath; the two integer square roots each take one restoring digit
//   per pipeline stage.
//   pipeline: COORD_BITS + 9 register stages from the input transaction to m_tvalid
//   (row decode 6 stages, COORD_BITS root stages, rounding, bounds, output).
//   reset: aresetn low clears the configuration registers to zero and the
//   valid bits of every stage, which empties the pipeline.
//   stall: while m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module rounded_outline_span_generator #(
    parameter int COORD_BITS = 13
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rosg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_wdata,
    // input rows
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // fields from bit 0: row
    input  logic [((COORD_BITS+8)/8)*8-1:0]      s_tdata,
    // result spans
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // fields from bit 0: left_valid, left_start, left_length,
    // right_valid, right_start, right_length
    output logic [((4*COORD_BITS+9)/8)*8-1:0]    m_tdata
);

    localparam int CB  = COORD_BITS;
    localparam int SB  = CB - 1;
    localparam int RB  = CB + 1;
    localparam int AW  = CB + 3;
    localparam int QW  = 2 * SB + 2;
    localparam int NS  = SB + 1;
    localparam int OF  = 2 * (1 + RB + SB);
    localparam int OW  = ((OF + 7) / 8) * 8;

    typedef struct packed {
        logic          has_res;
        logic [SB-1:0] r;
        logic [SB-1:0] t;
        logic [SB-1:0] ir;
        logic [SB-1:0] iw;
        logic          co;
        logic          ci;
        logic          inner;
    } ctx_t;

    // configuration registers
    logic [CB-1:0] rect_left_reg, rect_top_reg;
    logic [SB-1:0] rect_width_reg, rect_height_reg, corner_radius_reg, stroke_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rect_left_reg     <= '0;
            rect_top_reg      <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            corner_radius_reg <= '0;
            stroke_reg        <= '0;
        end else if (cfg_valid) begin
            case (rosg_pkg::cfg_reg_t'(cfg_index))
                rosg_pkg::REG_RECT_LEFT:        rect_left_reg     <= cfg_wdata;
                rosg_pkg::REG_RECT_TOP:         rect_top_reg      <= cfg_wdata;
                rosg_pkg::REG_RECT_WIDTH:       rect_width_reg    <= cfg_wdata[SB-1:0];
                rosg_pkg::REG_RECT_HEIGHT:      rect_height_reg   <= cfg_wdata[SB-1:0];
                rosg_pkg::REG_CORNER_RADIUS:    corner_radius_reg <= cfg_wdata[SB-1:0];
                rosg_pkg::REG_STROKE_THICKNESS: stroke_reg        <= cfg_wdata[SB-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance, held while the output transaction waits
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // widened config values
    logic signed [AW-1:0] x_e, y_e, w_e, h_e;
    assign x_e = AW'($signed(rect_left_reg));
    assign y_e = AW'($signed(rect_top_reg));
    assign w_e = $signed({{(AW-SB){1'b0}}, rect_width_reg});
    assign h_e = $signed({{(AW-SB){1'b0}}, rect_height_reg});

    // stage 1: capture row, clamp radius and thickness
    logic [SB-1:0] m_min, half_next, r_next, t_next;
    logic          empty_next;
    assign m_min      = (rect_width_reg < rect_height_reg) ? rect_width_reg : rect_height_reg;
    assign half_next  = m_min >> 1;
    assign r_next     = (corner_radius_reg > half_next) ? half_next : corner_radius_reg;
    assign t_next     = (stroke_reg > half_next) ? half_next : stroke_reg;
    assign empty_next = (rect_width_reg == '0) || (rect_height_reg == '0) ||
                        (stroke_reg == '0) || (m_min < SB'(2));

    logic                 v1_reg, empty1_reg;
    logic signed [AW-1:0] yy1_reg;
    logic [SB-1:0]        r1_reg, t1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            yy1_reg    <= AW'($signed(s_tdata[RB-1:0]));
            r1_reg     <= r_next;
            t1_reg     <= t_next;
            empty1_reg <= empty_next;
        end
    end

    // stage 2: row bounds of outer corners and hole
    logic signed [AW-1:0] r1_e, t1_e;
    assign r1_e = $signed({{(AW-SB){1'b0}}, r1_reg});
    assign t1_e = $signed({{(AW-SB){1'b0}}, t1_reg});

    logic                 v2_reg, empty2_reg;
    logic signed [AW-1:0] yy2_reg, yend2_reg, bto2_reg, bbo2_reg, bil2_reg, bih2_reg;
    logic signed [AW-1:0] iw2_reg, ih2_reg;
    logic [SB-1:0]        r2_reg, t2_reg, ir2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            yy2_reg    <= yy1_reg;
            empty2_reg <= empty1_reg;
            yend2_reg  <= y_e + h_e;
            bto2_reg   <= y_e + r1_e;
            bbo2_reg   <= y_e + h_e - r1_e;
            bil2_reg   <= y_e + t1_e;
            bih2_reg   <= y_e + h_e - t1_e;
            iw2_reg    <= w_e - (t1_e <<< 1);
            ih2_reg    <= h_e - (t1_e <<< 1);
            r2_reg     <= r1_reg;
            t2_reg     <= t1_reg;
            ir2_reg    <= (r1_reg > t1_reg) ? (r1_reg - t1_reg) : '0;
        end
    end

    // stage 3: inner corner bounds
    logic signed [AW-1:0] ir2_e;
    assign ir2_e = $signed({{(AW-SB){1'b0}}, ir2_reg});

    logic                 v3_reg, empty3_reg, hole3_reg;
    logic signed [AW-1:0] yy3_reg, yend3_reg, bto3_reg, bbo3_reg, bil3_reg, bih3_reg;
    logic signed [AW-1:0] bti3_reg, bbi3_reg;
    logic [SB-1:0]        r3_reg, t3_reg, ir3_reg, iw3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            yy3_reg    <= yy2_reg;
            empty3_reg <= empty2_reg;
            yend3_reg  <= yend2_reg;
            bto3_reg   <= bto2_reg;
            bbo3_reg   <= bbo2_reg;
            bil3_reg   <= bil2_reg;
            bih3_reg   <= bih2_reg;
            bti3_reg   <= bil2_reg + ir2_e;
            bbi3_reg   <= bih2_reg - ir2_e;
            hole3_reg  <= (iw2_reg > 0) && (ih2_reg > 0);
            iw3_reg    <= iw2_reg[SB-1:0];
            r3_reg     <= r2_reg;
            t3_reg     <= t2_reg;
            ir3_reg    <= ir2_reg;
        end
    end

    // stage 4: row classification and corner offsets
    logic                 top_o, top_i, in_rect;
    logic signed [AW-1:0] dyo_w, dyi_w;
    ctx_t                 ctx_next;
    assign in_rect = (yy3_reg >= y_e) && (yy3_reg < yend3_reg);
    assign top_o   = yy3_reg < bto3_reg;
    assign top_i   = yy3_reg < bti3_reg;
    assign dyo_w   = top_o ? (bto3_reg - yy3_reg) : (yy3_reg - bbo3_reg);
    assign dyi_w   = top_i ? (bti3_reg - yy3_reg) : (yy3_reg - bbi3_reg);

    always_comb begin
        ctx_next.has_res = in_rect && !empty3_reg;
        ctx_next.r       = r3_reg;
        ctx_next.t       = t3_reg;
        ctx_next.ir      = ir3_reg;
        ctx_next.iw      = iw3_reg;
        ctx_next.co      = (r3_reg != '0) && (top_o || (yy3_reg >= bbo3_reg));
        ctx_next.ci      = (ir3_reg != '0) && (top_i || (yy3_reg >= bbi3_reg));
        ctx_next.inner   = hole3_reg && (yy3_reg >= bil3_reg) && (yy3_reg < bih3_reg);
    end

    logic          v4_reg;
    ctx_t          ctx4_reg;
    logic [SB-1:0] dyo4_reg, dyi4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ctx4_reg <= ctx_next;
            dyo4_reg <= dyo_w[SB-1:0];
            dyi4_reg <= dyi_w[SB-1:0];
        end
    end

    // stage 5: squares
    logic              v5_reg;
    ctx_t              ctx5_reg;
    logic [2*SB-1:0]   ro5_reg, do5_reg, ri5_reg, di5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en)  v5_reg <= v4_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ctx5_reg <= ctx4_reg;
            ro5_reg  <= ctx4_reg.r * ctx4_reg.r;
            do5_reg  <= dyo4_reg * dyo4_reg;
            ri5_reg  <= ctx4_reg.ir * ctx4_reg.ir;
            di5_reg  <= dyi4_reg * dyi4_reg;
        end
    end

    // stage 6 and root stages: lane 0 outer, lane 1 inner
    logic [QW-1:0] rad_reg [0:1][0:NS];
    logic [QW-1:0] sq_reg  [0:1][0:NS];
    logic [SB:0]   res_reg [0:1][0:NS];
    ctx_t          ctxq_reg [0:NS];
    logic          vq_reg   [0:NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) vq_reg[0] <= 1'b0;
        else if (en)  vq_reg[0] <= v5_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ctxq_reg[0]   <= ctx5_reg;
            rad_reg[0][0] <= QW'(ro5_reg - do5_reg);
            rad_reg[1][0] <= QW'(ri5_reg - di5_reg);
            sq_reg[0][0]  <= '0;
            sq_reg[1][0]  <= '0;
            res_reg[0][0] <= '0;
            res_reg[1][0] <= '0;
        end
    end

    // one restoring root digit per stage, squares tracked incrementally
    for (genvar k = 0; k < NS; k++) begin : g_root
        localparam int B = SB - k;
        always_ff @(posedge aclk) begin
            if (!aresetn) vq_reg[k+1] <= 1'b0;
            else if (en)  vq_reg[k+1] <= vq_reg[k];
        end
        always_ff @(posedge aclk) begin
            if (en) ctxq_reg[k+1] <= ctxq_reg[k];
        end
        for (genvar ln = 0; ln < 2; ln++) begin : g_lane
            logic [QW-1:0] cand_next;
            assign cand_next = sq_reg[ln][k] + (QW'(res_reg[ln][k]) << (B + 1)) +
                               (QW'(1) << (2 * B));
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[ln][k+1] <= rad_reg[ln][k];
                    if (cand_next <= rad_reg[ln][k]) begin
                        sq_reg[ln][k+1]  <= cand_next;
                        res_reg[ln][k+1] <= res_reg[ln][k] | ((SB+1)'(1) << B);
                    end else begin
                        sq_reg[ln][k+1]  <= sq_reg[ln][k];
                        res_reg[ln][k+1] <= res_reg[ln][k];
                    end
                end
            end
        end
    end

    // rounding stage: bump root when remainder exceeds it
    logic        vr_reg;
    ctx_t        ctxr_reg;
    logic [SB:0] so_reg, si_reg;
    logic [QW-1:0] remo_w, remi_w;
    assign remo_w = rad_reg[0][NS] - sq_reg[0][NS];
    assign remi_w = rad_reg[1][NS] - sq_reg[1][NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) vr_reg <= 1'b0;
        else if (en)  vr_reg <= vq_reg[NS];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ctxr_reg <= ctxq_reg[NS];
            so_reg   <= res_reg[0][NS] + (SB+1)'(remo_w > QW'(res_reg[0][NS]));
            si_reg   <= res_reg[1][NS] + (SB+1)'(remi_w > QW'(res_reg[1][NS]));
        end
    end

    // bounds stage: outer and hole edges on this row
    logic signed [AW-1:0] r_e, t_e, ir_e, iw_e, so_e, si_e;
    assign r_e  = $signed({{(AW-SB){1'b0}}, ctxr_reg.r});
    assign t_e  = $signed({{(AW-SB){1'b0}}, ctxr_reg.t});
    assign ir_e = $signed({{(AW-SB){1'b0}}, ctxr_reg.ir});
    assign iw_e = $signed({{(AW-SB){1'b0}}, ctxr_reg.iw});
    assign so_e = $signed({{(AW-SB-1){1'b0}}, so_reg});
    assign si_e = $signed({{(AW-SB-1){1'b0}}, si_reg});

    logic                 vb_reg, hasb_reg, innerb_reg;
    logic signed [AW-1:0] ox0_reg, ox1_reg, ix0_reg, ix1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vb_reg <= 1'b0;
        else if (en)  vb_reg <= vr_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            hasb_reg   <= ctxr_reg.has_res;
            innerb_reg <= ctxr_reg.inner;
            ox0_reg    <= ctxr_reg.co ? (x_e + r_e - so_e) : x_e;
            ox1_reg    <= ctxr_reg.co ? (x_e + w_e - r_e + so_e) : (x_e + w_e);
            ix0_reg    <= ctxr_reg.ci ? (x_e + t_e + ir_e - si_e) : (x_e + t_e);
            ix1_reg    <= ctxr_reg.ci ? (x_e + t_e + iw_e - ir_e + si_e) : (x_e + t_e + iw_e);
        end
    end

    // output stage: span widths and result register
    logic signed [AW-1:0] lw_w, rw_w;
    logic                 lv_w, rv_w;
    logic [OF-1:0]        out_next;
    assign lw_w = innerb_reg ? (ix0_reg - ox0_reg) : (ox1_reg - ox0_reg);
    assign rw_w = innerb_reg ? (ox1_reg - ix1_reg) : '0;
    assign lv_w = lw_w > 0;
    assign rv_w = rw_w > 0;
    assign out_next = {
        rv_w ? rw_w[SB-1:0]    : {SB{1'b0}},
        rv_w ? ix1_reg[RB-1:0] : {RB{1'b0}},
        rv_w,
        lv_w ? lw_w[SB-1:0]    : {SB{1'b0}},
        lv_w ? ox0_reg[RB-1:0] : {RB{1'b0}},
        lv_w
    };

    logic [OF-1:0] m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)  m_tvalid_reg <= 1'b0;
        else if (en)   m_tvalid_reg <= vb_reg && hasb_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) m_data_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OW'(m_data_reg);

    // a valid left span never has zero length
    `ASSERT_IMP(a_left_len, aclk, aresetn, m_tvalid && m_data_reg[0], m_data_reg[RB+SB:RB+1] != '0)
    // a stalled pipeline keeps the valid bit of its bounds stage
    `ASSERT_IMP(a_stall_hold, aclk, aresetn, !en, ##1 $stable(vb_reg))
    // a right span only appears on rows that cross the hole
    `ASSERT_IMP(a_right_hole, aclk, aresetn, vb_reg && !innerb_reg, rw_w == '0)

endmodule
